// File: rtl/dfbpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfbpa_pkg
// shared types and constants for the dual fixed block pool allocator
// ----------------------------------------------------------------------------
package dfbpa_pkg;

    localparam int unsigned SLOT_W = 5;
    localparam int unsigned CNT_W  = 6;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic POOL_PLAIN = 1'b0;
    localparam logic POOL_DYN   = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_EXHAUSTED = 1'b1;

    typedef enum logic
    {
        POOL_IDLE,
        POOL_POP
    } pool_state_t;

    typedef struct packed
    {
        logic              action;
        logic [SLOT_W-1:0] slot_index;
    } pool_cmd_t;

    typedef struct packed
    {
        logic              status;
        logic [SLOT_W-1:0] granted_slot;
        logic [CNT_W-1:0]  used_count;
        logic [CNT_W-1:0]  free_count;
    } pool_result_t;

endpackage

// File: rtl/dfbpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfbpa_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module dfbpa_ram
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/dfbpa_pool.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfbpa_pool
// one lifo free list pool: head register, use count and next-link memory
// ----------------------------------------------------------------------------
module dfbpa_pool
#(
    parameter int unsigned DEPTH = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    input  dfbpa_pkg::pool_cmd_t    cmd,
    output logic                    busy,
    output logic                    done,
    output dfbpa_pkg::pool_result_t result
);

    import dfbpa_pkg::*;

    localparam int unsigned IW    = $clog2(DEPTH);
    localparam int unsigned LW    = $clog2(DEPTH + 1);
    localparam int unsigned CMP_W = (LW > SLOT_W) ? LW : SLOT_W;

    localparam logic [LW-1:0]    DEPTH_L = LW'(DEPTH);
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    pool_state_t    state_reg, state_next;
    logic [LW-1:0]  head_reg, head_next;
    logic [LW-1:0]  in_use_reg, in_use_next;
    logic [DEPTH-1:0] valid_reg, valid_next;
    logic           done_reg, done_next;
    pool_result_t   result_reg, result_next;

    logic           we;
    logic [IW-1:0]  waddr;
    logic [LW-1:0]  wdata;
    logic [IW-1:0]  head_idx;
    logic [LW-1:0]  rdata;
    logic [LW-1:0]  pop_link;
    logic           exhausted;
    logic           free_ok;

    assign head_idx = head_reg[IW-1:0];

    dfbpa_ram
    #(
        .WIDTH (LW),
        .DEPTH (DEPTH)
    )
    u_link_ram
    (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (head_idx),
        .rdata (rdata)
    );

    // links not yet written since reset are taken as pointing to the next slot
    assign pop_link  = valid_reg[head_idx] ? rdata : (head_reg + LW'(1));
    assign exhausted = (head_reg >= DEPTH_L) || (in_use_reg >= DEPTH_L);
    assign free_ok   = (in_use_reg != '0) && (CMP_W'(cmd.slot_index) < DEPTH_C);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= POOL_IDLE;
            head_reg   <= '0;
            in_use_reg <= '0;
            valid_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            in_use_reg <= in_use_next;
            valid_reg  <= valid_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        in_use_next  = in_use_reg;
        valid_next   = valid_reg;
        done_next    = 1'b0;
        we           = 1'b0;
        waddr        = IW'(cmd.slot_index);
        wdata        = head_reg;
        result_next  = result_reg;
        result_next.status       = STATUS_OK;
        result_next.granted_slot = '0;

        case (state_reg)
            POOL_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.action == ACT_ALLOC)
                    begin
                        if (exhausted)
                        begin
                            result_next.status = STATUS_EXHAUSTED;
                            done_next          = 1'b1;
                        end
                        else
                        begin
                            state_next = POOL_POP;
                        end
                    end
                    else
                    begin
                        if (free_ok)
                        begin
                            we                = 1'b1;
                            valid_next[waddr] = 1'b1;
                            head_next         = LW'(cmd.slot_index);
                            in_use_next       = in_use_reg - LW'(1);
                        end
                        done_next = 1'b1;
                    end
                end
            end
            POOL_POP:
            begin
                // granted slot's link becomes null
                we                       = 1'b1;
                waddr                    = head_idx;
                wdata                    = DEPTH_L;
                valid_next[head_idx]     = 1'b1;
                head_next                = pop_link;
                in_use_next              = in_use_reg + LW'(1);
                result_next.granted_slot = SLOT_W'(head_reg);
                done_next                = 1'b1;
                state_next               = POOL_IDLE;
            end
            default:
            begin
                state_next = POOL_IDLE;
            end
        endcase

        result_next.used_count = CNT_W'(in_use_next);
        result_next.free_count = CNT_W'(DEPTH_L - in_use_next);
    end

    assign busy   = (state_reg == POOL_POP);
    assign done   = done_reg;
    assign result = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_use_reg <= DEPTH_L)
        else $error("use count above pool depth");

    a_pop_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == POOL_POP |=> state_reg == POOL_IDLE && done_reg)
        else $error("pop did not complete in one cycle");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == POOL_POP |=> in_use_reg == $past(in_use_reg) + LW'(1))
        else $error("pop did not raise use count");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == POOL_IDLE)
        else $error("result while pop pending");

endmodule

// File: rtl/dual_fixed_block_pool_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_fixed_block_pool_allocator_unit
// two lifo free list slot pools, plain and dynamic, with allocate and free
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. A free, or an
// allocate on an exhausted pool, gives its result in the cycle after the
// transfer and leaves busy low, so such commands can follow every cycle. A
// successful allocate reads the head slot's next link from the pool's link
// memory, which has a registered read, holds busy high in the pop state and
// gives its result from the done register after that state. The result is
// shown for one cycle with done high and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module dual_fixed_block_pool_allocator_unit
#(
    parameter int unsigned PLAIN_POOL_DEPTH = 32,
    parameter int unsigned DYN_POOL_DEPTH   = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          action,
    input  logic                          pool_select,
    input  logic [dfbpa_pkg::SLOT_W-1:0]  slot_index,
    output logic                          done,
    output logic                          status,
    output logic [dfbpa_pkg::SLOT_W-1:0]  granted_slot,
    output logic [dfbpa_pkg::CNT_W-1:0]   used_count,
    output logic [dfbpa_pkg::CNT_W-1:0]   free_count
);

    import dfbpa_pkg::*;

    pool_cmd_t    cmd;
    logic         accept;
    logic         plain_busy, dyn_busy;
    logic         plain_done, dyn_done;
    pool_result_t plain_result, dyn_result;
    pool_result_t out_result;

    assign cmd.action     = action;
    assign cmd.slot_index = slot_index;
    assign busy           = plain_busy | dyn_busy;
    assign accept         = start & ~busy;

    dfbpa_pool
    #(
        .DEPTH (PLAIN_POOL_DEPTH)
    )
    u_plain_pool
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (accept && (pool_select == POOL_PLAIN)),
        .cmd       (cmd),
        .busy      (plain_busy),
        .done      (plain_done),
        .result    (plain_result)
    );

    dfbpa_pool
    #(
        .DEPTH (DYN_POOL_DEPTH)
    )
    u_dyn_pool
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (accept && (pool_select == POOL_DYN)),
        .cmd       (cmd),
        .busy      (dyn_busy),
        .done      (dyn_done),
        .result    (dyn_result)
    );

    assign out_result   = dyn_done ? dyn_result : plain_result;
    assign done         = plain_done | dyn_done;
    assign status       = out_result.status;
    assign granted_slot = out_result.granted_slot;
    assign used_count   = out_result.used_count;
    assign free_count   = out_result.free_count;

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        !(plain_done && dyn_done))
        else $error("both pools report a result");

    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(plain_busy && dyn_busy))
        else $error("both pools busy");

    a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("pending allocate gave no result");

endmodule

// File: tb/tb_dual_fixed_block_pool_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_fixed_block_pool_allocator_unit
// Self-checking bench for the two-pool slot allocator. A behavioral copy of
// both lifo free lists predicts status, granted slot and the counts for each
// command. Directed cases cover the reset order, lifo reuse, frees that are
// ignored, exhaustion at full depth and a double free on a full pool. Random
// alloc/free traffic with three sender idle profiles follows.
// ----------------------------------------------------------------------------
module tb_dual_fixed_block_pool_allocator_unit;

    import dfbpa_pkg::*;

    localparam int unsigned PLAIN_DEPTH    = 32;
    localparam int unsigned DYN_DEPTH      = 32;
    localparam int unsigned NUM_POOLS      = 2;
    localparam int unsigned MAX_SLOTS      = 32;
    localparam int unsigned DRAIN_CYCLES   = 6;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned PRINT_LIMIT    = 40;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                action;
    logic                pool_select;
    logic [SLOT_W-1:0]   slot_index;
    logic                done;
    logic                status;
    logic [SLOT_W-1:0]   granted_slot;
    logic [CNT_W-1:0]    used_count;
    logic [CNT_W-1:0]    free_count;

    // free list mirror
    logic [CNT_W-1:0]    pool_link [NUM_POOLS][MAX_SLOTS];
    logic [CNT_W-1:0]    pool_head [NUM_POOLS];
    int unsigned         pool_used [NUM_POOLS];

    // slots handed out and not yet returned, per pool
    int unsigned         held_cnt [NUM_POOLS][MAX_SLOTS];
    int unsigned         held_total [NUM_POOLS];
    bit                  draining [NUM_POOLS];

    pool_result_t        pending_outcomes [$];
    int unsigned         sender_idle_pct;
    int unsigned         mismatch_count;
    int unsigned         n_granted;
    int unsigned         n_exhausted;
    int unsigned         n_freed;
    int unsigned         n_ignored_frees;

    dual_fixed_block_pool_allocator_unit
    #(
        .PLAIN_POOL_DEPTH (PLAIN_DEPTH),
        .DYN_POOL_DEPTH   (DYN_DEPTH)
    )
    u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .pool_select  (pool_select),
        .slot_index   (slot_index),
        .done         (done),
        .status       (status),
        .granted_slot (granted_slot),
        .used_count   (used_count),
        .free_count   (free_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic reset_pool_model();
        for (int unsigned p = 0; p < NUM_POOLS; p++)
        begin
            for (int unsigned i = 0; i < MAX_SLOTS; i++)
            begin
                pool_link[p][i] = CNT_W'(i + 1);
                held_cnt[p][i]  = 0;
            end
            pool_head[p]  = '0;
            pool_used[p]  = 0;
            held_total[p] = 0;
            draining[p]   = 1'b0;
        end
    endtask

    function automatic pool_result_t compute_pool_outcome(input logic act, input logic pool,
                                                          input logic [SLOT_W-1:0] slot);
        pool_result_t      res;
        int unsigned       p;
        int unsigned       depth;
        logic [SLOT_W-1:0] taken;
        p     = int'(pool);
        depth = (pool == POOL_DYN) ? DYN_DEPTH : PLAIN_DEPTH;
        res   = '0;
        res.status = STATUS_OK;
        if (act == ACT_ALLOC)
        begin
            if (pool_head[p] >= depth || pool_used[p] >= depth)
                res.status = STATUS_EXHAUSTED;
            else
            begin
                taken               = pool_head[p][SLOT_W-1:0];
                res.granted_slot    = taken;
                pool_head[p]        = pool_link[p][taken];
                pool_link[p][taken] = CNT_W'(depth);
                pool_used[p]++;
            end
        end
        else if (pool_used[p] != 0 && slot < depth)
        begin
            pool_link[p][slot] = pool_head[p];
            pool_head[p]       = CNT_W'(slot);
            pool_used[p]--;
        end
        res.used_count = CNT_W'(pool_used[p]);
        res.free_count = CNT_W'(depth - pool_used[p]);
        return res;
    endfunction

    function automatic logic [SLOT_W-1:0] pick_held_slot(input int unsigned p, input bit skip_en,
                                                         input logic [SLOT_W-1:0] skip_slot);
        int unsigned offset;
        int unsigned idx;
        offset = $urandom_range(MAX_SLOTS - 1);
        for (int unsigned k = 0; k < MAX_SLOTS; k++)
        begin
            idx = (offset + k) % MAX_SLOTS;
            if (held_cnt[p][idx] != 0 && !(skip_en && idx == skip_slot))
                return SLOT_W'(idx);
        end
        return SLOT_W'(offset);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // one command transfer; start stays high afterwards unless the next call idles
    task automatic send_cmd(input logic act, input logic pool, input logic [SLOT_W-1:0] slot,
                            output pool_result_t outcome);
        int unsigned p;
        bit          was_in_use;
        p = int'(pool);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        start       <= 1'b1;
        action      <= act;
        pool_select <= pool;
        slot_index  <= slot;
        do
            @(posedge clk);
        while (busy);
        was_in_use = (pool_used[p] != 0);
        outcome    = compute_pool_outcome(act, pool, slot);
        pending_outcomes.push_back(outcome);
        if (act == ACT_ALLOC)
        begin
            if (outcome.status == STATUS_EXHAUSTED)
                n_exhausted++;
            else
            begin
                n_granted++;
                held_cnt[p][outcome.granted_slot]++;
                held_total[p]++;
            end
        end
        else if (!was_in_use)
            n_ignored_frees++;
        else
        begin
            n_freed++;
            if (held_cnt[p][slot] != 0)
            begin
                held_cnt[p][slot]--;
                held_total[p]--;
            end
        end
    endtask

    task automatic test_basic_alloc_free();
        pool_result_t r;
        send_cmd(ACT_ALLOC, POOL_PLAIN, 5'd31, r);
        send_cmd(ACT_ALLOC, POOL_DYN,   5'd0,  r);
        send_cmd(ACT_ALLOC, POOL_PLAIN, 5'd0,  r);
        send_cmd(ACT_FREE,  POOL_PLAIN, 5'd1,  r);
        send_cmd(ACT_ALLOC, POOL_PLAIN, 5'd21, r);
        send_cmd(ACT_FREE,  POOL_PLAIN, 5'd0,  r);
        send_cmd(ACT_FREE,  POOL_PLAIN, 5'd1,  r);
        send_cmd(ACT_FREE,  POOL_PLAIN, 5'd31, r);
        send_cmd(ACT_FREE,  POOL_DYN,   5'd0,  r);
        send_cmd(ACT_FREE,  POOL_DYN,   5'd0,  r);
        send_cmd(ACT_ALLOC, POOL_DYN,   5'd10, r);
        send_cmd(ACT_FREE,  POOL_DYN,   5'd0,  r);
    endtask

    task automatic test_fill_and_drain(input logic pool);
        pool_result_t r;
        int unsigned  p;
        p = int'(pool);
        for (int unsigned i = 0; i < MAX_SLOTS; i++)
            send_cmd(ACT_ALLOC, pool, SLOT_W'($urandom_range(MAX_SLOTS - 1)), r);
        send_cmd(ACT_ALLOC, pool, SLOT_W'($urandom_range(MAX_SLOTS - 1)), r);
        while (held_total[p] != 0)
            send_cmd(ACT_FREE, pool, pick_held_slot(p, 1'b0, '0), r);
    endtask

    // double free on a full pool keeps the list whole; the slot is then granted twice
    task automatic test_double_free_when_full(input logic pool);
        pool_result_t      r;
        int unsigned       p;
        logic [SLOT_W-1:0] twice;
        p = int'(pool);
        for (int unsigned i = 0; i < MAX_SLOTS; i++)
            send_cmd(ACT_ALLOC, pool, SLOT_W'($urandom_range(MAX_SLOTS - 1)), r);
        send_cmd(ACT_ALLOC, pool, 5'd0, r);
        twice = pick_held_slot(p, 1'b0, '0);
        send_cmd(ACT_FREE,  pool, twice, r);
        send_cmd(ACT_FREE,  pool, twice, r);
        send_cmd(ACT_ALLOC, pool, 5'd31, r);
        send_cmd(ACT_ALLOC, pool, 5'd0,  r);
        send_cmd(ACT_ALLOC, pool, 5'd31, r);
        send_cmd(ACT_FREE,  pool, twice, r);
        while (held_total[p] > held_cnt[p][twice])
            send_cmd(ACT_FREE, pool, pick_held_slot(p, 1'b1, twice), r);
        // nothing in use any more, so this one is ignored
        send_cmd(ACT_FREE, pool, twice, r);
        held_total[p]      -= held_cnt[p][twice];
        held_cnt[p][twice]  = 0;
    endtask

    task automatic test_random_traffic(input int unsigned n_items);
        pool_result_t      r;
        logic              act;
        logic              pool;
        logic [SLOT_W-1:0] slot;
        int unsigned       p;
        int unsigned       alloc_pct;
        for (int unsigned i = 0; i < n_items; i++)
        begin
            pool      = logic'($urandom_range(1));
            p         = int'(pool);
            alloc_pct = draining[p] ? 25 : 80;
            slot      = SLOT_W'($urandom_range(MAX_SLOTS - 1));
            if ($urandom_range(99) < 5)
                act = ACT_FREE;
            else if (held_total[p] == 0 || $urandom_range(99) < alloc_pct)
                act = ACT_ALLOC;
            else
            begin
                act  = ACT_FREE;
                slot = pick_held_slot(p, 1'b0, '0);
            end
            send_cmd(act, pool, slot, r);
            if (act == ACT_ALLOC && r.status == STATUS_EXHAUSTED)
                draining[p] = 1'b1;
            if (held_total[p] == 0)
                draining[p] = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        pool_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_outcomes.size() == 0)
                report_mismatch("result with no command outstanding");
            else
            begin
                want = pending_outcomes.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("status got %0h expected %0h",
                                              status, want.status));
                if (granted_slot !== want.granted_slot)
                    report_mismatch($sformatf("granted_slot got %0d expected %0d",
                                              granted_slot, want.granted_slot));
                if (used_count !== want.used_count)
                    report_mismatch($sformatf("used_count got %0d expected %0d",
                                              used_count, want.used_count));
                if (free_count !== want.free_count)
                    report_mismatch($sformatf("free_count got %0d expected %0d",
                                              free_count, want.free_count));
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((rst_n && start && !busy) || done === 1'b1)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        action          = ACT_ALLOC;
        pool_select     = POOL_PLAIN;
        slot_index      = '0;
        sender_idle_pct = 26;
        mismatch_count  = 0;
        n_granted       = 0;
        n_exhausted     = 0;
        n_freed         = 0;
        n_ignored_frees = 0;
        reset_pool_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_alloc_free();
        test_fill_and_drain(POOL_PLAIN);
        test_double_free_when_full(POOL_DYN);
        test_random_traffic(135);
        sender_idle_pct = 79;
        test_random_traffic(135);
        sender_idle_pct = 0;
        test_random_traffic(135);

        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d grants, %0d exhausted allocates, %0d frees, %0d ignored frees",
                 n_granted, n_exhausted, n_freed, n_ignored_frees);
        $display("both pools filled to exhaustion, double free on a full pool, %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: filelist.f
rtl/dfbpa_pkg.sv
rtl/dfbpa_ram.sv
rtl/dfbpa_pool.sv
rtl/dual_fixed_block_pool_allocator_unit.sv
tb/tb_dual_fixed_block_pool_allocator_unit.sv
